// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL; clk_i and rst_ni must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define PIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define PIP_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== hdl/pip_pkg.sv =====
package pip_pkg;

  // Coordinate format: signed Q11.4
  localparam int CoordBits = 16;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int CrossBits = ProdBits + 1;
  localparam int SeenBits  = 2;

  localparam logic [SeenBits-1:0] SeenNone = SeenBits'(0);
  localparam logic [SeenBits-1:0] SeenOne  = SeenBits'(1);
  localparam logic [SeenBits-1:0] SeenMax  = SeenBits'(3);

  localparam logic signed [CoordBits-1:0] RayEndReset = CoordBits'(1600);

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    coord_t query_x;
    coord_t query_y;
    logic   last_vertex;
  } pip_in_t;

  typedef struct packed {
    logic inside_res;
    logic too_few;
  } pip_out_t;

  // Control that travels with an item through the compute stage
  typedef struct packed {
    logic start;     // first vertex of a polygon, parity restarts
    logic edge_en;   // edge prev -> cur is tested
    logic close_en;  // closing edge cur -> first is tested, result is inside/outside
    logic last;      // item produces a result
    logic too_few;   // polygon ended with fewer than three vertices
  } pip_ctrl_t;

  typedef enum logic [1:0] {
    ORI_COLL = 2'd0,
    ORI_CW   = 2'd1,
    ORI_CCW  = 2'd2
  } orient_e;

  // Sign of the cross product (q - p) x (r - q), exact width
  function automatic orient_e orient(point_t p, point_t q, point_t r);
    logic signed [DiffBits-1:0]  d_qpy, d_rqx, d_qpx, d_rqy;
    logic signed [ProdBits-1:0]  m_a, m_b;
    logic signed [CrossBits-1:0] cross_val;
    d_qpy = DiffBits'(q.y) - DiffBits'(p.y);
    d_rqx = DiffBits'(r.x) - DiffBits'(q.x);
    d_qpx = DiffBits'(q.x) - DiffBits'(p.x);
    d_rqy = DiffBits'(r.y) - DiffBits'(q.y);
    m_a   = ProdBits'(d_qpy) * ProdBits'(d_rqx);
    m_b   = ProdBits'(d_qpx) * ProdBits'(d_rqy);
    cross_val = CrossBits'(m_a) - CrossBits'(m_b);
    if (cross_val == '0) begin
      return ORI_COLL;
    end else if (cross_val[CrossBits-1]) begin
      return ORI_CCW;
    end else begin
      return ORI_CW;
    end
  endfunction

  // Orientation of (q, e, r) where e lies on the horizontal through q:
  // the cross product reduces to -(e.x - q.x) * (r.y - q.y)
  function automatic orient_e ray_orient(coord_t qx, coord_t qy, coord_t ex, coord_t ry);
    if (ex == qx || ry == qy) begin
      return ORI_COLL;
    end else if ((ex > qx) != (ry > qy)) begin
      return ORI_CW;
    end else begin
      return ORI_CCW;
    end
  endfunction

  // q lies inside the bounding box of p and r
  function automatic logic on_seg(point_t p, point_t q, point_t r);
    coord_t xmax, xmin, ymax, ymin;
    xmax = (p.x > r.x) ? p.x : r.x;
    xmin = (p.x < r.x) ? p.x : r.x;
    ymax = (p.y > r.y) ? p.y : r.y;
    ymin = (p.y < r.y) ? p.y : r.y;
    return (q.x <= xmax) && (q.x >= xmin) && (q.y <= ymax) && (q.y >= ymin);
  endfunction

endpackage

// ===== hdl/pip_edge_test.sv =====
module pip_edge_test import pip_pkg::*; (
  input  point_t a_i,
  input  point_t b_i,
  input  point_t q_i,
  input  coord_t ray_x_i,
  output logic   toggle_o
);

  point_t  e_pt;
  orient_e o1, o2, o3, o4;
  logic    cross_gen, touch, meet;

  // Ray end shares the query's y
  assign e_pt.x = ray_x_i;
  assign e_pt.y = q_i.y;

  // Edge a-b against ray q-e; o3/o4 need no multiply since the ray is horizontal
  assign o1 = orient(a_i, b_i, q_i);
  assign o2 = orient(a_i, b_i, e_pt);
  assign o3 = ray_orient(q_i.x, q_i.y, ray_x_i, a_i.y);
  assign o4 = ray_orient(q_i.x, q_i.y, ray_x_i, b_i.y);

  assign cross_gen = (o1 != o2) && (o3 != o4);

  // Collinear touches; query-on-edge case is dropped below anyway
  assign touch = ((o2 == ORI_COLL) && on_seg(a_i, e_pt, b_i)) ||
                 ((o3 == ORI_COLL) && on_seg(q_i, a_i, e_pt)) ||
                 ((o4 == ORI_COLL) && on_seg(q_i, b_i, e_pt));

  assign meet = cross_gen || touch;

  // Edge counts only if the query is not collinear with it
  assign toggle_o = meet && (o1 != ORI_COLL);

endmodule

// ===== hdl/point_in_polygon_ray_cast_core.sv =====
// Point-in-polygon test by ray casting (crossing parity).
// Input channel: in_valid_i / in_stall_o / in_data_i, one polygon vertex per item,
// signed Q11.4. Every item carries the query point; it is taken from the first
// vertex of each polygon. last_vertex marks the final vertex.
// Output channel: out_valid_o / out_stall_i / out_data_o, one item per polygon,
// given for the last vertex: inside_res for odd crossing count, too_few when the
// polygon had fewer than three vertices.
// Config: cfg_we_i / cfg_data_i writes ray_end_x; write only while idle.
// Throughput: one vertex per cycle while the input is not stalled; the edge to the
// previous vertex and, on the last vertex, the closing edge are tested in parallel in one compute stage.
// Result path: accepting the last vertex loads the input register; its result
// then loads the result register once that register is free.
// Reset: polygon state cleared, ray_end_x = 100.0, no result pending.
// Stall: a held result keeps a following last vertex in the input register,
// which then stalls the input; other vertices pass while the result waits.
module point_in_polygon_ray_cast_core import pip_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  coord_t   cfg_data_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pip_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pip_out_t out_data_o
);

`include "assert_macros.svh"

  // Polygon state
  logic [SeenBits-1:0] seen_q, seen_d, seen_inc;
  point_t              first_q, first_d, prev_q, held_q, held_d;
  logic                parity_q, parity_d;
  coord_t              ray_q;

  // Input register
  logic      s1_valid_q, s1_valid_d;
  point_t    s1_a_q, s1_b_q, s1_f_q, s1_qp_q;
  pip_ctrl_t s1_ctrl_q, s1_ctrl_d;

  // Result register
  logic     out_valid_q, out_valid_d;
  pip_out_t out_data_q, out_data_d;

  logic   in_acc, s1_adv, out_free;
  logic   t_edge, t_close, par_new;
  point_t cur_pt;

  assign cur_pt.x = in_data_i.vertex_x;
  assign cur_pt.y = in_data_i.vertex_y;

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_ctrl_q.last || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Vertex count, query latch and control for the accepted item
  always_comb begin
    seen_inc = (seen_q == SeenNone) ? SeenOne :
               (seen_q == SeenMax)  ? SeenMax : seen_q + SeenOne;
    held_d   = held_q;
    first_d  = first_q;
    if (seen_q == SeenNone) begin
      held_d.x = in_data_i.query_x;
      held_d.y = in_data_i.query_y;
      first_d  = cur_pt;
    end
    seen_d             = in_data_i.last_vertex ? SeenNone : seen_inc;
    s1_ctrl_d.start    = (seen_q == SeenNone);
    s1_ctrl_d.edge_en  = (seen_q != SeenNone);
    s1_ctrl_d.last     = in_data_i.last_vertex;
    s1_ctrl_d.close_en = in_data_i.last_vertex && (seen_inc == SeenMax);
    s1_ctrl_d.too_few  = in_data_i.last_vertex && (seen_inc != SeenMax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= SeenNone;
      first_q <= '0;
      prev_q  <= '0;
      held_q  <= '0;
    end else if (in_acc) begin
      seen_q  <= seen_d;
      first_q <= first_d;
      prev_q  <= cur_pt;
      held_q  <= held_d;
    end
  end

  // Ray end register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_q <= RayEndReset;
    end else if (cfg_we_i) begin
      ray_q <= cfg_data_i;
    end
  end

  // Input register
  assign s1_valid_d = in_acc || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_ctrl_q  <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_acc) begin
        s1_ctrl_q <= s1_ctrl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_a_q  <= prev_q;
      s1_b_q  <= cur_pt;
      s1_f_q  <= first_d;
      s1_qp_q <= held_d;
    end
  end

  // Edge prev -> cur and closing edge cur -> first
  pip_edge_test u_edge (
    .a_i      (s1_a_q),
    .b_i      (s1_b_q),
    .q_i      (s1_qp_q),
    .ray_x_i  (ray_q),
    .toggle_o (t_edge)
  );

  pip_edge_test u_close (
    .a_i      (s1_b_q),
    .b_i      (s1_f_q),
    .q_i      (s1_qp_q),
    .ray_x_i  (ray_q),
    .toggle_o (t_close)
  );

  // Crossing parity
  assign par_new  = (s1_ctrl_q.start ? 1'b0 : parity_q)
                    ^ (s1_ctrl_q.edge_en && t_edge)
                    ^ (s1_ctrl_q.close_en && t_close);
  assign parity_d = s1_ctrl_q.last ? 1'b0 : par_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
    end else if (s1_adv) begin
      parity_q <= parity_d;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (s1_adv && s1_ctrl_q.last) begin
      out_valid_d           = 1'b1;
      out_data_d.inside_res = s1_ctrl_q.close_en && par_new;
      out_data_d.too_few    = s1_ctrl_q.too_few;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  `PIP_ASSERT(a_last_gives_result,
              (s1_adv && s1_ctrl_q.last) |=> out_valid_q,
              "last vertex lost its result")
  `PIP_ASSERT_NEVER(a_res_exclusive,
                    out_valid_q && out_data_q.inside_res && out_data_q.too_few,
                    "inside with too few vertices")
  `PIP_ASSERT(a_stall_cause,
              in_stall_o |-> (out_valid_q && out_stall_i),
              "input stalled without held result")
  `PIP_ASSERT(a_count_restart,
              (in_acc && in_data_i.last_vertex) |=> (seen_q == SeenNone),
              "vertex count not cleared")

endmodule

// ===== tb/tb_point_in_polygon_ray_cast_core.sv =====
module tb_point_in_polygon_ray_cast_core;
  import pip_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 2000;  // above the longest receiver hold-off
  localparam int LongHoldCycles = 300;
  localparam int SettleCycles  = 4;     // input reg + result reg, with margin
  localparam int ReportLimit   = 20;

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     cfg_we_i    = 1'b0;
  coord_t   cfg_data_i  = '0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  pip_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  pip_out_t out_data_o;

  point_in_polygon_ray_cast_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: mirrors the polygon tracker
  point_t   poly_first;
  point_t   poly_prev;
  point_t   poly_query;
  bit       poly_parity;
  int       poly_seen;
  coord_t   ray_end_x_q = RayEndReset;

  pip_out_t expected_verdicts[$];

  // Run statistics
  int fail_count     = 0;
  int vertices_sent  = 0;
  int polygons_sent  = 0;
  int inside_seen    = 0;
  int too_few_seen   = 0;
  int results_seen   = 0;
  int ray_settings   = 1;

  // Idling controls: idling_on for both sides, long_hold_req for the receiver
  bit idling_on      = 1'b1;
  bit long_hold_req  = 1'b0;

  // Exact sign of (q - p) x (r - q); 64-bit is wide enough for 16-bit coords
  function automatic orient_e turn_dir(point_t p, point_t q, point_t r);
    longint cross_val;
    cross_val = (longint'(q.y) - longint'(p.y)) * (longint'(r.x) - longint'(q.x))
              - (longint'(q.x) - longint'(p.x)) * (longint'(r.y) - longint'(q.y));
    if (cross_val == 0) begin
      return ORI_COLL;
    end else if (cross_val < 0) begin
      return ORI_CCW;
    end else begin
      return ORI_CW;
    end
  endfunction

  // q within the bounding box of p and r
  function automatic bit in_box(point_t p, point_t q, point_t r);
    coord_t xmax, xmin, ymax, ymin;
    xmax = (p.x > r.x) ? p.x : r.x;
    xmin = (p.x < r.x) ? p.x : r.x;
    ymax = (p.y > r.y) ? p.y : r.y;
    ymin = (p.y < r.y) ? p.y : r.y;
    return (q.x <= xmax) && (q.x >= xmin) && (q.y <= ymax) && (q.y >= ymin);
  endfunction

  function automatic bit edges_meet(point_t p1, point_t q1, point_t p2, point_t q2);
    orient_e o1, o2, o3, o4;
    o1 = turn_dir(p1, q1, p2);
    o2 = turn_dir(p1, q1, q2);
    o3 = turn_dir(p2, q2, p1);
    o4 = turn_dir(p2, q2, q1);
    if (o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == ORI_COLL && in_box(p1, p2, q1)) return 1'b1;
    if (o2 == ORI_COLL && in_box(p1, q2, q1)) return 1'b1;
    if (o3 == ORI_COLL && in_box(p2, p1, q2)) return 1'b1;
    if (o4 == ORI_COLL && in_box(p2, q1, q2)) return 1'b1;
    return 1'b0;
  endfunction

  // Edge a->b flips parity when it meets the ray and the query is off its line
  function automatic bit ray_crosses(point_t a, point_t b);
    point_t ray_tip;
    ray_tip.x = ray_end_x_q;
    ray_tip.y = poly_query.y;
    return edges_meet(a, b, poly_query, ray_tip) && (turn_dir(a, poly_query, b) != ORI_COLL);
  endfunction

  // Advance the polygon tracker by one accepted vertex
  task automatic track_vertex(input pip_in_t v);
    point_t   cur;
    pip_out_t verdict;
    cur.x = v.vertex_x;
    cur.y = v.vertex_y;
    if (poly_seen == 0) begin
      poly_first   = cur;
      poly_query.x = v.query_x;
      poly_query.y = v.query_y;
      poly_parity  = 1'b0;
      poly_seen    = 1;
    end else begin
      if (ray_crosses(poly_prev, cur)) poly_parity = ~poly_parity;
      if (poly_seen < 3) poly_seen++;
    end
    poly_prev = cur;
    if (v.last_vertex) begin
      if (poly_seen >= 3) begin
        if (ray_crosses(cur, poly_first)) poly_parity = ~poly_parity;
        verdict.inside_res = poly_parity;
        verdict.too_few    = 1'b0;
      end else begin
        verdict.inside_res = 1'b0;
        verdict.too_few    = 1'b1;
      end
      expected_verdicts.push_back(verdict);
      polygons_sent++;
      poly_seen   = 0;
      poly_parity = 1'b0;
    end
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t sat_coord(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return coord_t'(v);
  endfunction

  function automatic pip_in_t vtx(int x, int y, int qx, int qy, bit last);
    pip_in_t v;
    v.vertex_x    = coord_t'(x);
    v.vertex_y    = coord_t'(y);
    v.query_x     = coord_t'(qx);
    v.query_y     = coord_t'(qy);
    v.last_vertex = last;
    return v;
  endfunction

  function automatic int offset(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < ReportLimit) begin
      $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  // Offer one vertex, wait for it to be taken, then update the tracker
  task automatic send_vertex(input pip_in_t v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= v;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    vertices_sent++;
    track_vertex(v);
  endtask

  // Let every pending verdict come out and the pipeline settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_ray_end(input coord_t val);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ray_end_x_q  = val;
    ray_settings++;
  endtask

  // Result checker: compare each taken verdict with the oldest prediction
  always @(posedge clk_i) begin
    pip_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("verdict with no polygon pending", 1, 0);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_data_o.inside_res !== want.inside_res)
          report_mismatch("inside_res", out_data_o.inside_res, want.inside_res);
        if (out_data_o.too_few !== want.too_few)
          report_mismatch("too_few", out_data_o.too_few, want.too_few);
        if (want.inside_res) inside_seen++;
        if (want.too_few) too_few_seen++;
      end
    end
  end

  // Receiver stall: random bursts, plus one long hold-off on request
  initial begin : rx_stall_gen
    int burst;
    int hold;
    burst = 0;
    hold  = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold          = LongHoldCycles;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (idling_on && $urandom_range(0, 99) < 30) begin
        burst = pick_gap();
        out_stall_i <= (burst > 0);
        if (burst > 0) burst--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any item moving on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no progress for %0d cycles", WatchdogLimit);
    $display("tb_point_in_polygon_ray_cast_core: FAIL");
    $finish;
  end

  // Hand-built polygons at the reset ray end (100.0)
  task automatic test_default_ray();
    // square around the query: inside
    send_vertex(vtx(-160, -160, 0, 0, 1'b0));
    send_vertex(vtx( 160, -160, 0, 0, 1'b0));
    send_vertex(vtx( 160,  160, 0, 0, 1'b0));
    send_vertex(vtx(-160,  160, 0, 0, 1'b1));
    // query right of the ray end, later query fields are junk and ignored
    send_vertex(vtx(-160, -160, 3200, 0, 1'b0));
    send_vertex(vtx( 160, -160, -1, -1, 1'b0));
    send_vertex(vtx(   0,  160, 0, 12345, 1'b1));
    // too few vertices: one, then two
    send_vertex(vtx(5, 5, 0, 0, 1'b1));
    send_vertex(vtx(5, 5, 0, 0, 1'b0));
    send_vertex(vtx(50, 50, 0, 0, 1'b1));
    // query sits on a vertex, with a horizontal edge on the ray
    send_vertex(vtx(  0,   0, 0, 0, 1'b0));
    send_vertex(vtx(320,   0, 0, 0, 1'b0));
    send_vertex(vtx(  0, 320, 0, 0, 1'b1));
    // coordinate extremes
    send_vertex(vtx(-32768, -32768, 0, 0, 1'b0));
    send_vertex(vtx( 32767, -32768, 0, 0, 1'b0));
    send_vertex(vtx(     0,  32767, 0, 0, 1'b1));
  endtask

  // Ray end at its extremes, each time equal to the query x: zero-length rays
  task automatic test_ray_extremes();
    write_ray_end(16'sh7fff);
    send_vertex(vtx(32000, -100, 32767, 0, 1'b0));
    send_vertex(vtx(32767,  100, 32767, 0, 1'b0));
    send_vertex(vtx(32767, -300, 32767, 0, 1'b1));
    write_ray_end(16'sh8000);
    send_vertex(vtx(-160, -160, -32768, 32767, 1'b0));
    send_vertex(vtx( 160, -160, 0, 0, 1'b0));
    send_vertex(vtx( 160,  160, 0, 0, 1'b0));
    send_vertex(vtx(-160,  160, 0, 0, 1'b1));
  endtask

  // One random polygon: local, on a coarse grid around the query, or full range
  task automatic send_random_polygon();
    int      n;
    int      style;
    int      span;
    int      r;
    point_t  q;
    pip_in_t v;
    r = $urandom_range(0, 99);
    if (r < 6) n = 1;
    else if (r < 12) n = 2;
    else if (r < 80) n = $urandom_range(3, 6);
    else n = $urandom_range(7, 12);
    style = $urandom_range(0, 9);
    span  = ($urandom_range(0, 3) == 0) ? 2000 : 200;
    q.x = ($urandom_range(0, 2) == 0) ? sat_coord(int'(ray_end_x_q) + offset(span))
                                      : sat_coord(int'($urandom_range(0, 60000)) - 30000);
    q.y = sat_coord(int'($urandom_range(0, 60000)) - 30000);
    if (style >= 8) begin
      q.x = coord_t'($urandom);
      q.y = coord_t'($urandom);
    end
    for (int i = 0; i < n; i++) begin
      if (style <= 4) begin
        v.vertex_x = sat_coord(int'(q.x) + offset(span));
        v.vertex_y = sat_coord(int'(q.y) + offset(span));
      end else if (style <= 7) begin
        v.vertex_x = sat_coord(int'(q.x) + 16 * offset(4));
        v.vertex_y = sat_coord(int'(q.y) + 16 * offset(4));
      end else begin
        v.vertex_x = coord_t'($urandom);
        v.vertex_y = coord_t'($urandom);
      end
      v.query_x     = (i == 0) ? q.x : coord_t'($urandom);
      v.query_y     = (i == 0) ? q.y : coord_t'($urandom);
      v.last_vertex = (i == n - 1);
      send_vertex(v);
    end
  endtask

  // Random polygons over several ray settings, one phase without idling
  task automatic test_random_polygons();
    coord_t ray_list[5];
    int     start;
    ray_list = '{16'sh0000, coord_t'($urandom), 16'sh7fff, RayEndReset, 16'sh8000};
    for (int p = 0; p < 5; p++) begin
      write_ray_end(ray_list[p]);
      idling_on = (p != 2);
      start     = vertices_sent;
      while (vertices_sent - start < 200) send_random_polygon();
    end
    idling_on = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering polygons
  task automatic test_backpressure();
    write_ray_end(coord_t'($urandom));
    idling_on     = 1'b0;
    long_hold_req = 1'b1;
    for (int i = 0; i < 15; i++) begin
      send_vertex(vtx(-160 + offset(40), -160 + offset(40), offset(60), offset(60), 1'b0));
      send_vertex(vtx( 160 + offset(40), -160 + offset(40), 0, 0, 1'b0));
      send_vertex(vtx(offset(200), 160 + offset(40), 0, 0, 1'b1));
    end
    idling_on = 1'b1;
  endtask

  // Test sequence
  initial begin
    poly_seen   = 0;
    poly_parity = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_ray();
    test_ray_extremes();
    test_random_polygons();
    test_backpressure();
    wait_drained();

    $display("covered %0d vertices in %0d polygons under %0d ray end settings",
             vertices_sent, polygons_sent, ray_settings);
    $display("checked %0d verdicts: %0d inside, %0d too few, %0d mismatches",
             results_seen, inside_seen, too_few_seen, fail_count);
    if (fail_count == 0) begin
      $display("tb_point_in_polygon_ray_cast_core: PASS");
    end else begin
      $display("tb_point_in_polygon_ray_cast_core: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pip_pkg.sv
hdl/pip_edge_test.sv
hdl/point_in_polygon_ray_cast_core.sv
tb/tb_point_in_polygon_ray_cast_core.sv
